### hdl/cstr_pkg.sv
// ----------------------------------------------------------------------------
// cstr_pkg
// Types and constants shared by the capture sequencer blocks.
// ----------------------------------------------------------------------------
package cstr_pkg;

   localparam int unsigned CNT_W = 32;
   localparam int unsigned MS_W  = 32;
   localparam int unsigned SEQ_W = 3;

   localparam logic [MS_W-1:0] WAIT_TIMEOUT_RESET = MS_W'(1000);

   localparam logic [SEQ_W-1:0] SEQ_IDLE    = 3'd0;
   localparam logic [SEQ_W-1:0] SEQ_ARM     = 3'd1;
   localparam logic [SEQ_W-1:0] SEQ_WAIT    = 3'd2;
   localparam logic [SEQ_W-1:0] SEQ_TX      = 3'd3;
   localparam logic [SEQ_W-1:0] SEQ_RECOVER = 3'd4;

   typedef struct packed {
      logic            request;
      logic            start_ok;
      logic            dcmi_error;
      logic            frames_ready;
      logic            tx_ok;
      logic [MS_W-1:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic [SEQ_W-1:0] state_code;
      logic             request_active;
      logic             start_pulse;
      logic             recover_pulse;
      logic             abort_pulse;
      logic             transmit_pulse;
      logic [CNT_W-1:0] timeout_count;
      logic [CNT_W-1:0] tx_good_count;
      logic [CNT_W-1:0] tx_abort_count;
   } rsp_item_type;

endpackage

### hdl/cstr_intf.sv
// ----------------------------------------------------------------------------
// cstr channel interfaces
// Valid/ready channels for the tick beats and the result beats.
// ----------------------------------------------------------------------------
interface cstr_req_if
   import cstr_pkg::*;
   ;
   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cstr_rsp_if
   import cstr_pkg::*;
   ;
   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hdl/cstr_in_reg.sv
// ----------------------------------------------------------------------------
// cstr_in_reg
// Input register: holds one tick beat until the sequencer consumes it.
// ----------------------------------------------------------------------------
module cstr_in_reg
   import cstr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   cstr_req_if.sink     req_chan,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign valid_in       = take ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= req_chan.data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### hdl/cstr_core.sv
// ----------------------------------------------------------------------------
// cstr_core
// Five-state capture sequencer with wait timeout, one timeout retry and counters.
// ----------------------------------------------------------------------------
module cstr_core
   import cstr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [MS_W-1:0]  csr_wr_data,
   input  logic             step,
   input  req_item_type     item,
   output rsp_item_type     result
);

   typedef enum logic [SEQ_W-1:0] {
      ST_IDLE    = SEQ_IDLE,
      ST_ARM     = SEQ_ARM,
      ST_WAIT    = SEQ_WAIT,
      ST_TX      = SEQ_TX,
      ST_RECOVER = SEQ_RECOVER
   } seq_state_type;

   seq_state_type    state_ff, state_in;
   logic             pending_ff, pending_in;
   logic             active_ff, active_in;
   logic             retry_ff, retry_in;
   logic [MS_W-1:0]  wait_start_ff, wait_start_in;
   logic [MS_W-1:0]  timeout_ff;
   logic [CNT_W-1:0] timeouts_ff, timeouts_in;
   logic [CNT_W-1:0] good_ff, good_in;
   logic [CNT_W-1:0] aborted_ff, aborted_in;
   logic [MS_W-1:0]  elapsed;
   logic             p_start, p_rec, p_abort, p_tx;

   assign elapsed = item.now_ms - wait_start_ff;

   always_comb begin
      state_in      = state_ff;
      pending_in    = pending_ff | item.request;
      active_in     = active_ff;
      retry_in      = retry_ff;
      wait_start_in = wait_start_ff;
      timeouts_in   = timeouts_ff;
      good_in       = good_ff;
      aborted_in    = aborted_ff;
      p_start       = 1'b0;
      p_rec         = 1'b0;
      p_abort       = 1'b0;
      p_tx          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pending_in) begin
               pending_in = 1'b0;
               active_in  = 1'b1;
               retry_in   = 1'b0;
               state_in   = ST_ARM;
            end
         end
         ST_ARM: begin
            p_start = 1'b1;
            if (item.start_ok) begin
               wait_start_in = item.now_ms;
               state_in      = ST_WAIT;
            end else begin
               state_in = ST_RECOVER;
            end
         end
         ST_WAIT: begin
            if (item.dcmi_error) begin
               state_in = ST_RECOVER;
            end else if (item.frames_ready) begin
               state_in = ST_TX;
            end else if (elapsed > timeout_ff) begin
               timeouts_in = timeouts_ff + CNT_W'(1);
               if (!retry_ff) begin
                  retry_in = 1'b1;
                  state_in = ST_RECOVER;
               end else begin
                  p_abort   = 1'b1;
                  active_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_TX: begin
            p_tx = 1'b1;
            if (item.tx_ok) begin
               good_in = good_ff + CNT_W'(1);
            end else begin
               aborted_in = aborted_ff + CNT_W'(1);
            end
            active_in = 1'b0;
            retry_in  = 1'b0;
            state_in  = ST_IDLE;
         end
         ST_RECOVER: begin
            p_rec    = 1'b1;
            state_in = active_ff ? ST_ARM : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pending_ff    <= 1'b0;
         active_ff     <= 1'b0;
         retry_ff      <= 1'b0;
         wait_start_ff <= '0;
         timeouts_ff   <= '0;
         good_ff       <= '0;
         aborted_ff    <= '0;
         timeout_ff    <= WAIT_TIMEOUT_RESET;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (step) begin
            state_ff      <= state_in;
            pending_ff    <= pending_in;
            active_ff     <= active_in;
            retry_ff      <= retry_in;
            wait_start_ff <= wait_start_in;
            timeouts_ff   <= timeouts_in;
            good_ff       <= good_in;
            aborted_ff    <= aborted_in;
         end
      end
   end

   always_comb begin
      result.state_code     = state_in;
      result.request_active = active_in;
      result.start_pulse    = p_start;
      result.recover_pulse  = p_rec;
      result.abort_pulse    = p_abort;
      result.transmit_pulse = p_tx;
      result.timeout_count  = timeouts_in;
      result.tx_good_count  = good_in;
      result.tx_abort_count = aborted_in;
   end

endmodule

### hdl/cstr_out_reg.sv
// ----------------------------------------------------------------------------
// cstr_out_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module cstr_out_reg
   import cstr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type result,
   output logic         room,
   cstr_rsp_if.source   rsp_chan
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;

   assign room     = !valid_ff || rsp_chan.ready;
   assign valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.data  = data_ff;

endmodule

### hdl/capture_sequencer_timeout_retry.sv
// ----------------------------------------------------------------------------
// capture_sequencer_timeout_retry
// Capture sequencer top level: input register, sequencer step, result register.
//
//   channel   dir  width  content
//   req_chan  in   37     one tick: request, outcomes, flags, now_ms
//   rsp_chan  out  104    state, pulses and counters after the tick
//   csr_*     in   32     wait_timeout_ms write
//
// One beat per cycle sustained while the result side is ready; an accepted beat
// passes the input register, then the sequencer step loads the result register.
// Synchronous active-high reset clears state, counters and both valid flags,
// and loads wait_timeout_ms with 1000.
// A stalled result holds the result register; the input register refills as
// soon as its beat moves on, so the input stalls only behind a full pipe.
// ----------------------------------------------------------------------------
module capture_sequencer_timeout_retry
   import cstr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   cstr_req_if.sink        req_chan,
   cstr_rsp_if.source      rsp_chan,
   input  logic            csr_wr_en,
   input  logic [MS_W-1:0] csr_wr_data
);

   logic         item_valid;
   req_item_type item;
   rsp_item_type result;
   logic         room;
   logic         advance;

   assign advance = item_valid && room;

   cstr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   cstr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (advance),
      .item        (item),
      .result      (result)
   );

   cstr_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

### hdl/cstr_checker.sv
// ----------------------------------------------------------------------------
// cstr_checker
// Port-level checks on the result channel of the capture sequencer.
// ----------------------------------------------------------------------------
module cstr_checker
   import cstr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_data
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_pulses: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_data.start_pulse, rsp_data.recover_pulse,
                              rsp_data.abort_pulse, rsp_data.transmit_pulse}))
      else $error("more than one pulse in a beat");

   a_abort_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.abort_pulse |->
         rsp_data.state_code == SEQ_IDLE && !rsp_data.request_active)
      else $error("abort without return to idle");

   a_tx_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.transmit_pulse |->
         rsp_data.state_code == SEQ_IDLE && !rsp_data.request_active)
      else $error("transmit without return to idle");

   a_arm_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.start_pulse |->
         rsp_data.state_code == SEQ_WAIT || rsp_data.state_code == SEQ_RECOVER)
      else $error("arm attempt left sequencer in wrong state");

endmodule

bind capture_sequencer_timeout_retry cstr_checker u_cstr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

### tb/capture_sequencer_timeout_retry_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// capture_sequencer_timeout_retry_tb
// Self-checking bench for the capture sequencer. Tick beats go in through the
// req channel. Each one is run through a local model of the sequencer at the
// moment it is accepted. Status beats are compared field by field, in order.
// Directed sequences cover the arm, wait, transmit and recover paths, the
// priority in the wait state, the timeout retry and abort, and wrap of now_ms.
// Then modeled capture traffic runs under several wait limits, with random
// stalls on both sides, one long result hold and a final stretch at full rate.
// ----------------------------------------------------------------------------
module capture_sequencer_timeout_retry_tb;
   import cstr_pkg::*;

   localparam int unsigned LONG_HOLD_CYCLES = 60;
   localparam int unsigned WATCHDOG_LIMIT   = 2000;
   localparam int unsigned DRAIN_CYCLES     = 8;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [MS_W-1:0]   csr_wr_data;

   cstr_req_if req_chan();
   cstr_rsp_if rsp_chan();

   // sequencer model
   logic [SEQ_W-1:0]  seq_st        = SEQ_IDLE;
   logic              req_pend      = 1'b0;
   logic              active        = 1'b0;
   logic              retry_used    = 1'b0;
   logic [MS_W-1:0]   wait_t0       = '0;
   logic [MS_W-1:0]   wait_limit_ms = WAIT_TIMEOUT_RESET;
   logic [CNT_W-1:0]  n_timeouts    = '0;
   logic [CNT_W-1:0]  n_good        = '0;
   logic [CNT_W-1:0]  n_aborted     = '0;

   rsp_item_type      status_q[$];
   logic [MS_W-1:0]   stream_now    = '0;
   bit                idle_en       = 1'b1;
   bit                hold_request  = 1'b0;
   int unsigned       tick_beats    = 0;
   int unsigned       status_beats  = 0;
   int unsigned       n_mismatch    = 0;
   int unsigned       n_limits      = 0;
   int unsigned       stall_cycles  = 0;

   capture_sequencer_timeout_retry i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic rsp_item_type step_sequencer(req_item_type t);
      rsp_item_type    r;
      logic [MS_W-1:0] elapsed;
      r = '0;
      elapsed = t.now_ms - wait_t0;
      if (t.request) req_pend = 1'b1;
      case (seq_st)
         SEQ_IDLE: begin
            if (req_pend) begin
               req_pend   = 1'b0;
               active     = 1'b1;
               retry_used = 1'b0;
               seq_st     = SEQ_ARM;
            end
         end
         SEQ_ARM: begin
            r.start_pulse = 1'b1;
            if (t.start_ok) begin
               wait_t0 = t.now_ms;
               seq_st  = SEQ_WAIT;
            end else begin
               seq_st = SEQ_RECOVER;
            end
         end
         SEQ_WAIT: begin
            if (t.dcmi_error) begin
               seq_st = SEQ_RECOVER;
            end else if (t.frames_ready) begin
               seq_st = SEQ_TX;
            end else if (elapsed > wait_limit_ms) begin
               n_timeouts = n_timeouts + CNT_W'(1);
               if (!retry_used) begin
                  retry_used = 1'b1;
                  seq_st     = SEQ_RECOVER;
               end else begin
                  r.abort_pulse = 1'b1;
                  active        = 1'b0;
                  seq_st        = SEQ_IDLE;
               end
            end
         end
         SEQ_TX: begin
            r.transmit_pulse = 1'b1;
            if (t.tx_ok) n_good = n_good + CNT_W'(1);
            else n_aborted = n_aborted + CNT_W'(1);
            active     = 1'b0;
            retry_used = 1'b0;
            seq_st     = SEQ_IDLE;
         end
         SEQ_RECOVER: begin
            r.recover_pulse = 1'b1;
            seq_st = active ? SEQ_ARM : SEQ_IDLE;
         end
         default: begin
            seq_st = SEQ_IDLE;
         end
      endcase
      r.state_code     = seq_st;
      r.request_active = active;
      r.timeout_count  = n_timeouts;
      r.tx_good_count  = n_good;
      r.tx_abort_count = n_aborted;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         n_mismatch++;
      end
   endtask

   // tick beats are modeled on acceptance, status beats checked in order
   always @(posedge clock) begin
      rsp_item_type e;
      rsp_item_type a;
      if (!reset && req_chan.valid && req_chan.ready) begin
         status_q.push_back(step_sequencer(req_chan.data));
         tick_beats++;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         status_beats++;
         a = rsp_chan.data;
         if (status_q.size() == 0) begin
            $error("status beat with no tick pending: %0h", a);
            n_mismatch++;
         end else begin
            e = status_q.pop_front();
            check_field("state_code", 32'(e.state_code), 32'(a.state_code));
            check_field("request_active", 32'(e.request_active), 32'(a.request_active));
            check_field("start_pulse", 32'(e.start_pulse), 32'(a.start_pulse));
            check_field("recover_pulse", 32'(e.recover_pulse), 32'(a.recover_pulse));
            check_field("abort_pulse", 32'(e.abort_pulse), 32'(a.abort_pulse));
            check_field("transmit_pulse", 32'(e.transmit_pulse), 32'(a.transmit_pulse));
            check_field("timeout_count", e.timeout_count, a.timeout_count);
            check_field("tx_good_count", e.tx_good_count, a.tx_good_count);
            check_field("tx_abort_count", e.tx_abort_count, a.tx_abort_count);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $error("watchdog: no beat for %0d cycles", stall_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // result side: random stalls, one long hold on request
   initial begin
      int unsigned gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (idle_en && $urandom_range(4) == 0) begin
            gap = $urandom_range(1, 4);
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic req_item_type mk_tick(int unsigned req, int unsigned ok,
                                            int unsigned err, int unsigned rdy,
                                            int unsigned txok, logic [MS_W-1:0] now);
      req_item_type t;
      t.request      = 1'(req);
      t.start_ok     = 1'(ok);
      t.dcmi_error   = 1'(err);
      t.frames_ready = 1'(rdy);
      t.tx_ok        = 1'(txok);
      t.now_ms       = now;
      return t;
   endfunction

   // modeled capture traffic with a running clock; noise jumps the clock
   function automatic req_item_type gen_tick(logic [MS_W-1:0] step_max, int unsigned noise_pct);
      req_item_type t;
      if ($urandom_range(99) < noise_pct) begin
         t = mk_tick($urandom_range(1), $urandom_range(1), $urandom_range(1),
                     $urandom_range(1), $urandom_range(1), $urandom);
      end else begin
         stream_now += $urandom_range(step_max);
         t = mk_tick(int'($urandom_range(7) == 0), int'($urandom_range(7) != 0),
                     int'($urandom_range(15) == 0), int'($urandom_range(5) == 0),
                     int'($urandom_range(3) != 0), stream_now);
      end
      stream_now = t.now_ms;
      return t;
   endfunction

   task automatic send_tick(input req_item_type t);
      int unsigned gap;
      if (idle_en && $urandom_range(4) == 0) begin
         gap = $urandom_range(1, 4);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= t;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   task automatic wait_drained;
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (status_q.size() != 0);
   endtask

   task automatic set_wait_limit(input logic [MS_W-1:0] limit);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      wait_limit_ms = limit;
      n_limits++;
   endtask

   task automatic run_traffic(int unsigned n, logic [MS_W-1:0] limit,
                              logic [MS_W-1:0] step_max, int unsigned noise_pct);
      set_wait_limit(limit);
      repeat (n) send_tick(gen_tick(step_max, noise_pct));
   endtask

   // runs at the reset limit of 1000 ms
   task automatic test_directed_sequence;
      send_tick(mk_tick(1, 0, 0, 0, 0, 32'h0000_0000));   // idle -> arm
      send_tick(mk_tick(0, 0, 0, 0, 0, 32'h0000_0001));   // arm fails
      send_tick(mk_tick(0, 0, 0, 0, 0, 32'h0000_0002));   // recover -> arm
      send_tick(mk_tick(0, 1, 0, 0, 0, 32'hFFFF_FF00));
      send_tick(mk_tick(0, 0, 1, 1, 0, 32'hFFFF_FF01));   // error beats ready
      send_tick(mk_tick(0, 0, 0, 0, 0, 32'hFFFF_FF02));
      send_tick(mk_tick(0, 1, 0, 0, 0, 32'hFFFF_FFF0));
      send_tick(mk_tick(0, 0, 0, 1, 0, 32'h0000_07C0));   // ready beats timeout, wrapped
      send_tick(mk_tick(1, 0, 0, 0, 1, 32'h0000_07C1));   // good send, request held
      send_tick(mk_tick(0, 0, 0, 0, 0, 32'h0000_07C2));   // pending request starts
      send_tick(mk_tick(0, 1, 0, 0, 0, 32'h0000_0064));
      send_tick(mk_tick(1, 0, 0, 0, 0, 32'h0000_044C));   // elapsed equals limit
      send_tick(mk_tick(0, 0, 0, 0, 0, 32'h0000_044D));   // first timeout, retry
      send_tick(mk_tick(0, 0, 0, 0, 0, 32'h0000_044E));
      send_tick(mk_tick(0, 1, 0, 0, 0, 32'h0000_1388));
      send_tick(mk_tick(0, 0, 0, 0, 0, 32'h0000_1771));   // second timeout, abort
      send_tick(mk_tick(0, 0, 0, 0, 0, 32'h0000_1772));   // pending request starts
      send_tick(mk_tick(1, 1, 1, 1, 1, 32'hFFFF_FFFF));
      send_tick(mk_tick(1, 0, 0, 1, 1, 32'hFFFF_FFFF));
      send_tick(mk_tick(0, 1, 1, 0, 0, 32'h0000_0000));   // failed send
      send_tick(mk_tick(0, 0, 0, 0, 0, 32'h0000_0000));
      send_tick(mk_tick(0, 1, 1, 1, 1, 32'hAAAA_5555));   // arm succeeds, stray flags ignored
      send_tick(mk_tick(0, 0, 0, 1, 0, 32'h5555_AAAA));
      send_tick(mk_tick(0, 1, 1, 1, 0, 32'h0000_0000));
      send_tick(mk_tick(0, 0, 0, 0, 0, 32'h0000_0000));
   endtask

   task automatic test_wait_limit_extremes;
      set_wait_limit(32'h0000_0000);
      send_tick(mk_tick(1, 0, 0, 0, 0, 32'h0000_0010));
      send_tick(mk_tick(0, 1, 0, 0, 0, 32'h0000_0010));
      send_tick(mk_tick(0, 0, 0, 0, 0, 32'h0000_0010));   // no elapsed time
      send_tick(mk_tick(0, 0, 0, 0, 0, 32'h0000_0011));   // timeout at one
      set_wait_limit(32'hFFFF_FFFF);
      send_tick(mk_tick(1, 0, 0, 0, 0, 32'h0000_0000));
      send_tick(mk_tick(0, 1, 0, 0, 0, 32'h0000_0000));
      send_tick(mk_tick(0, 1, 0, 0, 0, 32'h0000_0000));
      send_tick(mk_tick(0, 1, 0, 0, 0, 32'hFFFF_FFFF));   // never times out
      send_tick(mk_tick(0, 0, 0, 1, 0, 32'h8000_0000));
      send_tick(mk_tick(0, 0, 0, 0, 1, 32'h8000_0001));
   endtask

   task automatic test_random_traffic;
      run_traffic(400, 32'd5, 32'd3, 8);
      run_traffic(400, 32'd40, 32'd15, 8);
      run_traffic(300, 32'd1000, 32'd400, 8);
      run_traffic(200, 32'd0, 32'd2, 8);
      run_traffic(150, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8);
   endtask

   task automatic test_backpressure;
      set_wait_limit(32'd12);
      hold_request = 1'b1;
      repeat (24) send_tick(gen_tick(32'd6, 0));
      wait_drained();
      repeat (10) send_tick(gen_tick(32'd6, 10));
   endtask

   task automatic test_steady_stream;
      idle_en = 1'b0;
      run_traffic(400, 32'd20, 32'd8, 5);
   endtask

   initial begin
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_sequence();
      test_wait_limit_extremes();
      test_random_traffic();
      test_backpressure();
      test_steady_stream();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d tick beats and %0d status beats over %0d wait limits.",
               tick_beats, status_beats, n_limits);
      $display("Model saw %0d timeouts, %0d good and %0d aborted sends.",
               n_timeouts, n_good, n_aborted);
      if (n_mismatch == 0 && status_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
